// ===== hw/rtl/itrd_pkg.sv =====
package itrd_pkg;

    // Field widths and defaults
    localparam int VALUE_BITS_DEF = 31;
    localparam int RADIX_W        = 6;
    localparam int CHAR_W         = 7;

    localparam logic [RADIX_W-1:0] RADIX_RESET   = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
    localparam logic [RADIX_W-1:0] DECIMAL_LIMIT = 6'd10;
    localparam logic [CHAR_W-1:0]  LETTER_OFFSET = 7'd55;
    localparam logic [CHAR_W-1:0]  ZERO_CHAR     = 7'd48;

    // Conversion sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_EMIT
    } state_t;

    // Status of the bit-serial divider towards the sequencer
    typedef struct packed {
        logic               done;
        logic               quot_zero;
        logic [RADIX_W-1:0] remainder;
    } div_status_t;

    // Digit value to ASCII character
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d >= DECIMAL_LIMIT) begin
            c = {1'b0, d} + LETTER_OFFSET;
        end else begin
            c = {1'b0, d} + ZERO_CHAR;
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/itrd_divider.sv =====
module itrd_divider #(
    parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [VALUE_BITS-1:0]         dividend,
    input  logic [itrd_pkg::RADIX_W-1:0]  radix,
    output logic [VALUE_BITS-1:0]         quotient,
    output itrd_pkg::div_status_t         status
);
    import itrd_pkg::*;

    localparam int CNT_W = $clog2(VALUE_BITS);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(VALUE_BITS - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] shift_reg, shift_next;
    logic [RADIX_W-1:0]    rem_reg, rem_next;

    logic [RADIX_W:0]      trial;
    logic                  ge;

    // One restoring division step: dividend bits leave at the top, quotient bits enter below
    assign trial = {rem_reg, shift_reg[VALUE_BITS-1]};
    assign ge    = (trial >= {1'b0, radix});

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        if (start) begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = dividend;
            rem_next   = '0;
        end else if (busy_reg) begin
            shift_next = {shift_reg[VALUE_BITS-2:0], ge};
            rem_next   = ge ? RADIX_W'(trial - {1'b0, radix}) : trial[RADIX_W-1:0];
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == LAST_BIT) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign quotient         = shift_reg;
    assign status.done      = done_reg;
    assign status.quot_zero = (shift_reg == '0);
    assign status.remainder = rem_reg;

`ifndef ASSERT_OFF
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg && !done_reg)
        else $error("divider did not start");
    a_last_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !start && cnt_reg == LAST_BIT) |=> done_reg)
        else $error("divider missed its final step");
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> rem_reg < radix)
        else $error("remainder not below radix");
`endif

endmodule

// ===== hw/rtl/integer_to_radix_digits_unit.sv =====
// Sequence: each digit takes one division at one quotient bit a cycle, and its remainder is
// pushed onto the digit stack; each character is popped into rd_data_reg, then loaded into the
// output register once it is free. Throughput: one value at a time; the bit-serial divider
// sets it. The next value is taken while the last character waits.
// Reset: aresetn is synchronous, active low; radix returns to 10, control and output clear.
module integer_to_radix_digits_unit #(
    parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // radix
    input  logic                                cfg_wr_en,
    input  logic [itrd_pkg::RADIX_W-1:0]        cfg_wr_data,
    // s_tdata: value [VALUE_BITS-1:0], zero padded to whole bytes
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_tdata,
    // m_tdata: digit_char [6:0], zero at [7]; m_tlast: last_digit
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,
    output logic                                m_tlast
);
    import itrd_pkg::*;

    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam int ADR_W = $clog2(VALUE_BITS);

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [RADIX_W-1:0]    radix_reg;
    logic [RADIX_W-1:0]    digit_stack [VALUE_BITS];
    logic [RADIX_W-1:0]    rd_data_reg;
    logic                  m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]     m_char_reg;
    logic                  m_last_reg;

    logic [VALUE_BITS-1:0] value_in;
    logic                  value_zero;
    logic                  div_start;
    logic [VALUE_BITS-1:0] div_dividend;
    logic [VALUE_BITS-1:0] div_quot;
    div_status_t           div_st;
    logic                  push_en;
    logic [RADIX_W-1:0]    push_data;
    logic                  rd_en;
    logic [CNT_W-1:0]      count_dec;
    logic                  out_free;
    logic                  out_load;

    assign value_in   = s_tdata[VALUE_BITS-1:0];
    assign value_zero = (value_in == '0);
    assign count_dec  = count_reg - 1'b1;
    assign out_free   = !m_valid_reg || m_tready;

    itrd_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .radix    (radix_reg),
        .quotient (div_quot),
        .status   (div_st)
    );

    // Radix register, clamped to 2..36 on write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_wr_data < RADIX_MIN) begin
                radix_reg <= RADIX_MIN;
            end else if (cfg_wr_data > RADIX_MAX) begin
                radix_reg <= RADIX_MAX;
            end else begin
                radix_reg <= cfg_wr_data;
            end
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = value_zero ? ST_READ : ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_st.done && div_st.quot_zero) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = (count_reg == '0) ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_tready     = 1'b0;
        div_start    = 1'b0;
        div_dividend = value_in;
        push_en      = 1'b0;
        push_data    = div_st.remainder;
        rd_en        = 1'b0;
        out_load     = 1'b0;
        count_next   = count_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    count_next = '0;
                    if (value_zero) begin
                        // zero converts to the single digit 0
                        push_en    = 1'b1;
                        push_data  = '0;
                        count_next = CNT_W'(1);
                    end else begin
                        div_start = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (div_st.done) begin
                    push_en    = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (!div_st.quot_zero) begin
                        div_start    = 1'b1;
                        div_dividend = div_quot;
                    end
                end
            end
            ST_READ: begin
                rd_en      = 1'b1;
                count_next = count_dec;
            end
            ST_EMIT: begin
                out_load = out_free;
            end
            default: begin
                count_next = '0;
            end
        endcase
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_char_reg <= digit_to_ascii(rd_data_reg);
            m_last_reg <= (count_reg == '0);
        end
    end

    // Digit stack
    always_ff @(posedge aclk) begin
        if (push_en) begin
            digit_stack[count_next == '0 ? '0 : ADR_W'(count_reg)] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= digit_stack[count_dec[ADR_W-1:0]];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_char_reg};
    assign m_tlast  = m_last_reg;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(VALUE_BITS))
        else $error("digit stack overflow");
    a_radix_range: assert property (@(posedge aclk) disable iff (!aresetn)
        radix_reg >= RADIX_MIN && radix_reg <= RADIX_MAX)
        else $error("radix out of range");
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_DIV || state_reg == ST_READ))
        else $error("accepted item not started");
    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && count_reg == '0) |=> (m_tvalid && m_tlast && state_reg == ST_IDLE))
        else $error("final character not flagged");
    a_read_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |-> count_reg != '0)
        else $error("pop from empty stack");
`endif

endmodule
